// File: design/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Needs nothing else; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at once whenever a trigger holds.
`define ASSERT_IMPLY(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed: label");

// A condition that must hold in the cycle after a trigger holds.
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed: label");

`endif

// File: design/esie_pkg.sv
// Shared types and constants of the ES descriptor specific-info extractor.
// Used by every module of the block; depends on nothing.
package esie_pkg;

   localparam int MaxLengthBytesDefault = 4;
   localparam int QueueDepthDefault = 2;
   localparam int LenWidth = 28;
   localparam int CountWidth = 3;
   localparam int SkipWidth = 4;

   localparam logic [7:0] TagEs = 8'h03;
   localparam logic [7:0] TagConfig = 8'h04;
   localparam logic [7:0] TagSpecific = 8'h05;
   localparam logic [SkipWidth-1:0] SkipEs = 4'd3;
   localparam logic [SkipWidth-1:0] SkipOther = 4'd2;
   localparam logic [SkipWidth-1:0] SkipConfig = 4'd13;

   localparam logic [1:0] KindByte = 2'd0;
   localparam logic [1:0] KindOk = 2'd1;
   localparam logic [1:0] KindErr = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_flag;
      logic       cont;
      logic       is_es;
      logic       is_config;
      logic       is_specific;
   } item_type;

endpackage

// File: design/esie_front.sv
// Front end: classifies each incoming cookie byte into an item for the queue.
// Depends on esie_pkg.
module esie_front (
   input  logic [7:0]        data_byte,
   input  logic              end_of_cookie,
   output esie_pkg::item_type item
);
   import esie_pkg::*;

   always_comb begin
      item.data_byte = data_byte;
      item.end_flag = end_of_cookie;
      item.cont = data_byte[7];
      item.is_es = (data_byte == TagEs);
      item.is_config = (data_byte == TagConfig);
      item.is_specific = (data_byte == TagSpecific);
   end

endmodule

// File: design/esie_queue.sv
// Short FIFO that parts the classifying front end from the parser.
// Depends on esie_pkg for the item type.
module esie_queue #(
   parameter int DEPTH = esie_pkg::QueueDepthDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  esie_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output esie_pkg::item_type head_item
);
   import esie_pkg::*;

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCount = CntWidth'(DEPTH);

   item_type            mem_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   assign full = (count_ff == FullCount);
   assign not_empty = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/esie_engine.sv
// Back end: descriptor parser state machine and the result output register.
// Depends on esie_pkg.
module esie_engine #(
   parameter int MAX_LENGTH_BYTES = esie_pkg::MaxLengthBytesDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  esie_pkg::item_type item,
   output logic               item_take,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [7:0]         rsp_payload_byte,
   output logic               rsp_last
);
   import esie_pkg::*;

   localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_LENGTH_BYTES);

   typedef enum logic [3:0] {
      PH_TAG1, PH_LEN1, PH_SKIP1, PH_TAG2, PH_LEN2,
      PH_SKIP2, PH_TAG3, PH_LEN3, PH_PAYLOAD, PH_DRAIN
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [LenWidth-1:0]   acc_ff, acc_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic [SkipWidth-1:0]  skip_ff, skip_in;
   logic                  es_ff, es_in;
   logic [LenWidth-1:0]   rem_ff, rem_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            kind_ff, kind_in;
   logic [7:0]            byte_ff, byte_in;
   logic                  last_ff, last_in;

   logic                  out_free;
   logic                  have;
   logic                  done;
   logic [LenWidth-1:0]   acc_take;
   logic [CountWidth-1:0] cnt_take;
   logic                  hdr_done;
   logic [SkipWidth-1:0]  skip_dec;
   logic [LenWidth-1:0]   rem_dec;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign item_take = item_valid && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = kind_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_last = last_ff;

   assign acc_take = {acc_ff[LenWidth-8:0], item.data_byte[6:0]};
   assign cnt_take = cnt_ff + 1'b1;
   assign hdr_done = !item.cont || (cnt_take >= MaxCount);
   assign skip_dec = skip_ff - 1'b1;
   assign rem_dec = rem_ff - 1'b1;

   always_comb begin
      phase_in = phase_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      skip_in = skip_ff;
      es_in = es_ff;
      rem_in = rem_ff;
      have = 1'b0;
      done = 1'b0;
      kind_in = KindErr;
      byte_in = '0;
      last_in = 1'b1;
      unique case (phase_ff)
         PH_TAG1: begin
            es_in = item.is_es;
            acc_in = '0;
            cnt_in = '0;
            phase_in = PH_LEN1;
         end
         PH_LEN1: begin
            acc_in = acc_take;
            cnt_in = cnt_take;
            if (hdr_done) begin
               skip_in = es_ff ? SkipEs : SkipOther;
               phase_in = PH_SKIP1;
            end
         end
         PH_SKIP1: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               phase_in = PH_TAG2;
            end
         end
         PH_TAG2: begin
            if (!item.is_config) begin
               have = 1'b1;
               done = 1'b1;
            end else begin
               acc_in = '0;
               cnt_in = '0;
               phase_in = PH_LEN2;
            end
         end
         PH_LEN2: begin
            acc_in = acc_take;
            cnt_in = cnt_take;
            if (hdr_done) begin
               skip_in = SkipConfig;
               phase_in = PH_SKIP2;
            end
         end
         PH_SKIP2: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               phase_in = PH_TAG3;
            end
         end
         PH_TAG3: begin
            if (!item.is_specific) begin
               have = 1'b1;
               done = 1'b1;
            end else begin
               acc_in = '0;
               cnt_in = '0;
               phase_in = PH_LEN3;
            end
         end
         PH_LEN3: begin
            acc_in = acc_take;
            cnt_in = cnt_take;
            if (hdr_done) begin
               rem_in = acc_take;
               if (acc_take == '0) begin
                  have = 1'b1;
                  done = 1'b1;
                  kind_in = KindOk;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            rem_in = rem_dec;
            have = 1'b1;
            kind_in = KindByte;
            byte_in = item.data_byte;
            last_in = (rem_dec == '0);
            done = (rem_dec == '0);
         end
         PH_DRAIN: begin
            done = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase

      if (item.end_flag && !done) begin
         have = 1'b1;
         done = 1'b1;
         kind_in = KindErr;
         byte_in = '0;
         last_in = 1'b1;
      end

      if (done) begin
         if (item.end_flag) begin
            phase_in = PH_TAG1;
            acc_in = '0;
            cnt_in = '0;
            skip_in = '0;
            es_in = 1'b0;
            rem_in = '0;
         end else begin
            phase_in = PH_DRAIN;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = item_take && have;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG1;
         acc_ff <= '0;
         cnt_ff <= '0;
         skip_ff <= '0;
         es_ff <= 1'b0;
         rem_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_take) begin
            phase_ff <= phase_in;
            acc_ff <= acc_in;
            cnt_ff <= cnt_in;
            skip_ff <= skip_in;
            es_ff <= es_in;
            rem_ff <= rem_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take && have) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         last_ff <= last_in;
      end
   end

endmodule

// File: design/esds_specific_info_extractor.sv
// ES descriptor decoder-specific-info extractor, top level.
// Depends on esie_pkg, esie_front, esie_queue and esie_engine.
//
// Usage: cookie bytes arrive on the req_ channel, one byte per transfer,
// with req_end_of_cookie set on the final byte. The parser walks the ES,
// decoder-config and decoder-specific descriptor headers and returns on the
// rsp_ channel each specific-info byte (kind 0, last on the final one), a
// success with no payload (kind 1) or an error (kind 2). A byte that gives
// no result (header, skipped or drained bytes) produces no rsp_ transfer.
// Throughput: one byte per cycle while the receiver keeps taking results.
// Path: each byte is first written into the input queue; the parser step then
// takes it from the queue head and lands its result in the output register,
// which can wait behind earlier queued bytes or a stalled receiver.
// When the receiver stalls, the output register holds its result and the
// input queue keeps accepting until it is full; req_ready then drops.
// Reset clears the queue, the parser and the output valid flag; the block
// waits for the first tag of a new cookie. No clearing pass is needed.
module esds_specific_info_extractor #(
   parameter int MAX_LENGTH_BYTES = esie_pkg::MaxLengthBytesDefault,
   parameter int QUEUE_DEPTH = esie_pkg::QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_cookie,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_last
);
   import esie_pkg::*;

   item_type front_item;
   item_type head_item;
   logic     q_full;
   logic     q_not_empty;
   logic     q_pop;
   logic     q_push;

   assign req_ready = !q_full;
   assign q_push = req_valid && !q_full;

   esie_front u_front (
      .data_byte     (req_data_byte),
      .end_of_cookie (req_end_of_cookie),
      .item          (front_item)
   );

   esie_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_item (head_item)
   );

   esie_engine #(
      .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (q_not_empty),
      .item             (head_item),
      .item_take        (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_last         (rsp_last)
   );

endmodule

// File: design/esie_checker.sv
// Port-level checker for the extractor, bound to the top level.
// Depends on esie_pkg and assert_macros.svh.
`include "assert_macros.svh"

module esie_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_last
);
   import esie_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_kind) && $stable(rsp_payload_byte) && $stable(rsp_last))
   `ASSERT_IMPLY(a_kind_legal, clock, reset, rsp_valid,
      rsp_kind == KindByte || rsp_kind == KindOk || rsp_kind == KindErr)
   `ASSERT_IMPLY(a_status_shape, clock, reset, rsp_valid && rsp_kind != KindByte,
      rsp_last && rsp_payload_byte == 8'h00)
   `ASSERT_NEXT(a_no_result_after_reset, clock, 1'b0, reset, !rsp_valid)

endmodule

bind esds_specific_info_extractor esie_checker u_esie_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_last         (rsp_last)
);

// File: sim/tb_esds_specific_info_extractor.sv
// Testbench for esds_specific_info_extractor: drives cookies, mostly well formed, and checks
// every result against a cycle-free model of the descriptor parser kept in a small class.
// Depends on esie_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_esds_specific_info_extractor;
   import esie_pkg::*;

   typedef enum logic [3:0] {
      PhTag1, PhLen1, PhSkip1, PhTag2, PhLen2, PhSkip2, PhTag3, PhLen3, PhPayload, PhDrain
   } parse_phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload;
      logic       last;
   } extract_result_type;

   class extract_tracker;
      parse_phase_type    phase;
      logic [27:0]        len_acc;
      logic [2:0]         len_count;
      logic [3:0]         skip_left;
      logic               es_first;
      logic [27:0]        bytes_left;
      int                 max_groups;
      extract_result_type awaited_results[$];
      int                 failures;

      function new(int groups);
         max_groups = groups;
         failures = 0;
         restart();
      endfunction

      function void restart();
         phase = PhTag1;
         len_acc = '0;
         len_count = '0;
         skip_left = '0;
         es_first = 1'b0;
         bytes_left = '0;
      endfunction

      function void open_header();
         len_acc = '0;
         len_count = '0;
      endfunction

      function bit take_group(logic [7:0] b);
         len_acc = {len_acc[20:0], b[6:0]};
         len_count = len_count + 3'd1;
         return !b[7] || (int'(len_count) >= max_groups);
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      function void note_byte(logic [7:0] b, logic eoc);
         extract_result_type res;
         bit have;
         bit done;
         have = 1'b0;
         done = 1'b0;
         res.kind = KindErr;
         res.payload = 8'h00;
         res.last = 1'b1;
         case (phase)
            PhTag1: begin
               es_first = (b == TagEs);
               open_header();
               phase = PhLen1;
            end
            PhLen1: begin
               if (take_group(b)) begin
                  skip_left = es_first ? SkipEs : SkipOther;
                  phase = PhSkip1;
               end
            end
            PhSkip1: begin
               skip_left = skip_left - 4'd1;
               if (skip_left == 4'd0) phase = PhTag2;
            end
            PhTag2: begin
               if (b != TagConfig) begin
                  have = 1'b1;
                  done = 1'b1;
               end else begin
                  open_header();
                  phase = PhLen2;
               end
            end
            PhLen2: begin
               if (take_group(b)) begin
                  skip_left = SkipConfig;
                  phase = PhSkip2;
               end
            end
            PhSkip2: begin
               skip_left = skip_left - 4'd1;
               if (skip_left == 4'd0) phase = PhTag3;
            end
            PhTag3: begin
               if (b != TagSpecific) begin
                  have = 1'b1;
                  done = 1'b1;
               end else begin
                  open_header();
                  phase = PhLen3;
               end
            end
            PhLen3: begin
               if (take_group(b)) begin
                  bytes_left = len_acc;
                  if (bytes_left == '0) begin
                     have = 1'b1;
                     done = 1'b1;
                     res.kind = KindOk;
                  end else begin
                     phase = PhPayload;
                  end
               end
            end
            PhPayload: begin
               bytes_left = bytes_left - 28'd1;
               have = 1'b1;
               res.kind = KindByte;
               res.payload = b;
               res.last = (bytes_left == '0);
               done = (bytes_left == '0);
            end
            default: begin
               if (eoc) restart();
               else phase = PhDrain;
               return;
            end
         endcase
         if (eoc && !done) begin
            have = 1'b1;
            done = 1'b1;
            res.kind = KindErr;
            res.payload = 8'h00;
            res.last = 1'b1;
         end
         if (done) begin
            if (eoc) restart();
            else phase = PhDrain;
         end
         if (have) awaited_results.push_back(res);
      endfunction

      function void check_result(logic [1:0] kind, logic [7:0] pbyte, logic last);
         extract_result_type exp;
         if (awaited_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: kind %0d byte %02h last %0b", kind, pbyte, last);
            return;
         end
         exp = awaited_results.pop_front();
         if (exp.kind !== kind || exp.payload !== pbyte || exp.last !== last) begin
            failures++;
            if (failures <= 10) begin
               $write("mismatch: expected kind %0d byte %02h last %0b",
                      exp.kind, exp.payload, exp.last);
               $display(", got kind %0d byte %02h last %0b", kind, pbyte, last);
            end
         end
      endfunction
   endclass

   localparam int MaxLenGroups = MaxLengthBytesDefault;
   localparam int CycleLimit = 500000;
   localparam int PayloadCap = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_cookie = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_payload_byte;
   logic       rsp_last;

   extract_tracker sb;
   logic [7:0]     cookie_bytes[$];
   int             send_idle_pct = 33;
   int             recv_idle_pct = 67;
   int             bytes_sent = 0;
   int             cycle_count = 0;

   esds_specific_info_extractor #(
      .MAX_LENGTH_BYTES(MaxLenGroups)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_end_of_cookie(req_end_of_cookie),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_last(rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_kind, rsp_payload_byte, rsp_last);
         if (req_valid && req_ready) sb.note_byte(req_data_byte, req_end_of_cookie);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb_esds_specific_info_extractor: FAIL");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eoc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_end_of_cookie <= eoc;
      bytes_sent++;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic push_length(input logic [27:0] value, input int groups, input bit long_form);
      logic [27:0] shifted;
      for (int i = groups - 1; i >= 0; i--) begin
         shifted = value >> (7 * i);
         cookie_bytes.push_back({(i != 0) || long_form, shifted[6:0]});
      end
   endtask

   task automatic send_noise(input int n);
      for (int i = 0; i < n; i++)
         send_byte(8'($urandom), (i == n - 1) ? 1'b1 : ($urandom_range(7) == 0));
   endtask

   // A cookie is built in full, then the end flag goes on the last byte kept.
   task automatic send_cookie(input logic [7:0] first_tag, input logic [7:0] second_tag,
                              input logic [7:0] third_tag, input logic [27:0] payload_len,
                              input int len3_groups, input bit len3_long, input int drop,
                              input int tail);
      int g;
      int n_payload;
      int keep;
      cookie_bytes.delete();
      cookie_bytes.push_back(first_tag);
      g = $urandom_range(1, MaxLenGroups);
      push_length(28'($urandom), g, (g == MaxLenGroups) && ($urandom_range(3) == 0));
      for (int i = 0; i < int'((first_tag == TagEs) ? SkipEs : SkipOther); i++)
         cookie_bytes.push_back(8'($urandom));
      cookie_bytes.push_back(second_tag);
      g = $urandom_range(1, MaxLenGroups);
      push_length(28'($urandom), g, (g == MaxLenGroups) && ($urandom_range(3) == 0));
      for (int i = 0; i < int'(SkipConfig); i++) cookie_bytes.push_back(8'($urandom));
      cookie_bytes.push_back(third_tag);
      push_length(payload_len, len3_long ? MaxLenGroups : len3_groups, len3_long);
      n_payload = (payload_len > PayloadCap) ? PayloadCap : int'(payload_len);
      for (int i = 0; i < n_payload + tail; i++) cookie_bytes.push_back(8'($urandom));
      keep = cookie_bytes.size() - drop;
      if (keep < 1) keep = 1;
      for (int i = 0; i < keep; i++) send_byte(cookie_bytes[i], i == keep - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin
      int start;
      int r;
      int min_groups;
      logic [7:0] t1;
      logic [7:0] t2;
      logic [7:0] t3;
      logic [27:0] plen;
      bit long3;
      sb = new(MaxLenGroups);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_byte(8'hff, 1'b1);
      send_cookie(TagEs, 8'h00, TagSpecific, 28'd0, 1, 1'b0, 0, 2);
      send_cookie(8'h00, TagConfig, 8'hff, 28'd0, 1, 1'b0, 0, 1);
      send_cookie(TagEs, TagConfig, TagSpecific, 28'd0, 1, 1'b0, 0, 1);
      send_cookie(TagEs, TagConfig, TagSpecific, 28'd0, MaxLenGroups, 1'b1, 0, 0);
      send_cookie(8'h7f, TagConfig, TagSpecific, 28'd3, MaxLenGroups, 1'b0, 0, 0);
      send_cookie(TagEs, TagConfig, TagSpecific, 28'd1, MaxLenGroups, 1'b1, 0, 2);
      send_cookie(TagEs, TagConfig, TagSpecific, 28'd5, 1, 1'b0, 3, 0);
      send_cookie(TagEs, TagConfig, TagSpecific, 28'd2, 1, 1'b0, 9, 0);
      send_cookie(TagEs, TagConfig, TagSpecific, 28'hfffffff, MaxLenGroups, 1'b0, 0, 0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(8'hff, 1'b1);
      wait_drained();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 67 : 0;
         recv_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 33 : 0;
         start = bytes_sent;
         while (bytes_sent - start < 230) begin
            r = $urandom_range(99);
            if (r < 10) begin
               send_noise($urandom_range(1, 20));
            end else begin
               t1 = $urandom_range(1) ? TagEs : 8'($urandom);
               t2 = ($urandom_range(9) != 0) ? TagConfig : 8'($urandom);
               t3 = ($urandom_range(9) != 0) ? TagSpecific : 8'($urandom);
               r = $urandom_range(99);
               if (r < 75) plen = 28'($urandom_range(0, 12));
               else if (r < 90) plen = 28'($urandom_range(13, 60));
               else plen = 28'($urandom);
               min_groups = 1;
               while (min_groups < MaxLenGroups && (plen >> (7 * min_groups)) != 0)
                  min_groups++;
               long3 = ($urandom_range(9) == 0);
               send_cookie(t1, t2, t3, plen, $urandom_range(min_groups, MaxLenGroups), long3,
                           ($urandom_range(6) == 0) ? $urandom_range(1, 30) : 0,
                           $urandom_range(0, 3));
            end
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("tb_esds_specific_info_extractor: PASS");
      end else begin
         $display("tb_esds_specific_info_extractor: FAIL");
      end
      $finish;
   end

endmodule
